/* design/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define HVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define HVR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HVR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/hvr_pkg.sv */
`default_nettype none
package hvr_pkg;

  localparam int unsigned BC_W       = 32;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned DVS_W      = 33;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned RING_PRIME = 991;
  localparam int unsigned SPREAD_DIV = 7;
  localparam int unsigned SPREAD_MUL = 6;

  // register index codes (paddr[2])
  localparam logic REG_RING_SIZE = 1'b0;

  // phases of the spacing derivation after a register write
  localparam logic [CNT_W-1:0] STEPS_CFG  = 7'd3;
  localparam logic [CNT_W-1:0] CFG_PH_HI  = 7'd2;
  localparam logic [CNT_W-1:0] CFG_PH_QUO = 7'd1;

  // iteration counts of the serial divider
  localparam logic [CNT_W-1:0] STEPS_KEY  = 7'd64;
  localparam logic [CNT_W-1:0] STEPS_FOLD = 7'd33;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_CFG,
    FS_MOD1,
    FS_MOD2,
    FS_PUSH
  } front_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

  typedef struct packed {
    logic            no_blocks;
    logic [BC_W-1:0] start;
    logic [BC_W-1:0] step;
  } ring_job_t;

endpackage
`default_nettype wire

/* design/hvr_div.sv */
`default_nettype none
// one restoring divider lane, one quotient bit per cycle while step is high
module hvr_div (
  input  wire                                 clk,
  input  wire hvr_pkg::lane_ctl_t             ctl,
  input  wire  [hvr_pkg::KEY_W-1:0]           dividend,
  input  wire  [hvr_pkg::DVS_W-1:0]           divisor,
  output logic [hvr_pkg::DVS_W-1:0]           rem
);

  logic [hvr_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [hvr_pkg::KEY_W-1:0] dvd_r, dvd_nxt;
  logic [hvr_pkg::DVS_W-1:0] dvs_r;
  logic [hvr_pkg::DVS_W:0]   trial;
  logic [hvr_pkg::DVS_W:0]   diff;

  // shift in next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, dvd_r[hvr_pkg::KEY_W-1]};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = diff[hvr_pkg::DVS_W-1:0];
      dvd_nxt = {dvd_r[hvr_pkg::KEY_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[hvr_pkg::DVS_W-1:0];
      dvd_nxt = {dvd_r[hvr_pkg::KEY_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (ctl.step) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign rem = rem_r;

endmodule
`default_nettype wire

/* design/hvr_front.sv */
`default_nettype none
// accepts hosts, derives start and spacing with two serial divider lanes
module hvr_front #(
  parameter int unsigned VNODES = 3
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr,
  input  wire  [hvr_pkg::BC_W-1:0]     ring_size,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [31:0]                  in_ip_word,
  input  wire  [15:0]                  in_port_number,
  output logic                         job_valid,
  output hvr_pkg::ring_job_t           job,
  input  wire                          job_full
);

  // reciprocal of VNODES*7, exact for every 32-bit ring size
  localparam int unsigned DIV_C    = hvr_pkg::SPREAD_DIV * VNODES;
  localparam int unsigned RECIP_SH = 32 + $clog2(DIV_C);
  localparam logic [63:0] RECIP_M  = ((64'd1 << RECIP_SH) / 64'(DIV_C)) + 64'd1;
  localparam logic [15:0] RECIP_LO = RECIP_M[15:0];
  localparam logic [16:0] RECIP_HI = RECIP_M[32:16];
  localparam logic [6:0]  DIV_K    = 7'(DIV_C);
  localparam logic [hvr_pkg::DVS_W-1:0] PRIME_C = hvr_pkg::DVS_W'(hvr_pkg::RING_PRIME);

  hvr_pkg::front_state_t state_r, state_nxt;
  logic [hvr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [hvr_pkg::BC_W-1:0]  q_r, base_r;
  logic                      nob_r;
  logic [64:0]               acc_r;

  hvr_pkg::lane_ctl_t        ctl_a, ctl_b;
  logic [hvr_pkg::KEY_W-1:0] dvd_a, dvd_b;
  logic [hvr_pkg::DVS_W-1:0] dvs_a, dvs_b, rem_a, rem_b;
  logic [hvr_pkg::KEY_W-1:0] key;
  logic [47:0]               prod_lo;
  logic [48:0]               prod_hi;
  logic [64:0]               acc_sh;
  logic [31:0]               rem_c, base_c;
  logic [9:0]                six_r;
  logic [2:0]                frac;
  logic                      accept, ld_item, ld_fold, run, cnt_done;
  logic [hvr_pkg::BC_W-1:0]  spacing;

  assign key      = {in_ip_word, in_port_number, 16'd0};
  assign prod_lo  = ring_size * RECIP_LO;
  assign prod_hi  = ring_size * RECIP_HI;
  assign acc_sh   = acc_r >> RECIP_SH;
  assign cnt_done = (cnt_r == '0);
  assign accept   = (state_r == hvr_pkg::FS_IDLE) && !cfg_wr && in_valid;
  assign ld_item  = accept && (ring_size != '0);
  assign ld_fold  = (state_r == hvr_pkg::FS_MOD1) && cnt_done;
  assign run      = !cnt_done && ((state_r == hvr_pkg::FS_CFG) ||
                    (state_r == hvr_pkg::FS_MOD1) || (state_r == hvr_pkg::FS_MOD2));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hvr_pkg::FS_IDLE: begin
        if (accept) state_nxt = (ring_size == '0) ? hvr_pkg::FS_PUSH : hvr_pkg::FS_MOD1;
      end
      hvr_pkg::FS_CFG:  if (cnt_done) state_nxt = hvr_pkg::FS_IDLE;
      hvr_pkg::FS_MOD1: if (cnt_done) state_nxt = hvr_pkg::FS_MOD2;
      hvr_pkg::FS_MOD2: if (cnt_done) state_nxt = hvr_pkg::FS_PUSH;
      hvr_pkg::FS_PUSH: if (!job_full) state_nxt = hvr_pkg::FS_IDLE;
      default:          state_nxt = hvr_pkg::FS_IDLE;
    endcase
    if (cfg_wr) state_nxt = hvr_pkg::FS_CFG;
  end

  // lane control and operand selection
  always_comb begin
    ctl_a.load = ld_item || ld_fold;
    ctl_a.step = !cnt_done &&
                 ((state_r == hvr_pkg::FS_MOD1) || (state_r == hvr_pkg::FS_MOD2));
    ctl_b.load = ld_item;
    ctl_b.step = !cnt_done && (state_r == hvr_pkg::FS_MOD1);
    if (ld_fold) begin
      dvd_a = {rem_a, 31'd0};
      dvs_a = {1'b0, ring_size};
    end else begin
      dvd_a = key;
      dvs_a = {1'b0, ring_size} + PRIME_C;
    end
    dvd_b = key;
    dvs_b = {1'b0, q_r};
    cnt_nxt = cnt_r;
    if (cfg_wr)       cnt_nxt = hvr_pkg::STEPS_CFG;
    else if (ld_item) cnt_nxt = hvr_pkg::STEPS_KEY;
    else if (ld_fold) cnt_nxt = hvr_pkg::STEPS_FOLD;
    else if (run)     cnt_nxt = cnt_r - 1'b1;
  end

  // spread base: six times the quotient plus the share of the remainder
  always_comb begin
    rem_c = ring_size - (q_r * {25'd0, DIV_K});
    six_r = ({3'd0, rem_c[6:0]} << 2) + ({3'd0, rem_c[6:0]} << 1);
    frac  = '0;
    for (int k = 1; k < 6; k++) begin
      if (six_r >= 10'(k * DIV_C)) frac = frac + 3'd1;
    end
    base_c = (q_r << 2) + (q_r << 1) + {29'd0, frac};
  end

  // handshake and job outputs
  always_comb begin
    in_stall  = (state_r != hvr_pkg::FS_IDLE) || cfg_wr;
    job_valid = (state_r == hvr_pkg::FS_PUSH);
    if (q_r == '0) spacing = (ring_size == 32'd1) ? '0 : 32'd1;
    else           spacing = rem_b[hvr_pkg::BC_W-1:0] + base_r;
    job.no_blocks = nob_r;
    job.start     = rem_a[hvr_pkg::BC_W-1:0];
    job.step      = spacing;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hvr_pkg::FS_IDLE;
      cnt_r   <= '0;
      q_r     <= '0;
      base_r  <= '0;
      nob_r   <= 1'b0;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (accept) nob_r <= (ring_size == '0);
      // spacing terms after a register write, one phase per cycle until another write restarts them
      if (!cfg_wr && (state_r == hvr_pkg::FS_CFG)) begin
        if (cnt_r == hvr_pkg::STEPS_CFG)       acc_r  <= {17'd0, prod_lo};
        else if (cnt_r == hvr_pkg::CFG_PH_HI)  acc_r  <= acc_r + {prod_hi, 16'd0};
        else if (cnt_r == hvr_pkg::CFG_PH_QUO) q_r    <= acc_sh[31:0];
        else if (cnt_done)                     base_r <= base_c;
      end
    end
  end

  hvr_div u_lane_a (
    .clk(clk), .ctl(ctl_a), .dividend(dvd_a), .divisor(dvs_a), .rem(rem_a)
  );

  hvr_div u_lane_b (
    .clk(clk), .ctl(ctl_b), .dividend(dvd_b), .divisor(dvs_b), .rem(rem_b)
  );

endmodule
`default_nettype wire

/* design/hvr_fifo.sv */
`default_nettype none
// two-entry job queue between front and back
module hvr_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wire hvr_pkg::ring_job_t push_job,
  output logic                full,
  input  wire                 pop,
  output logic                not_empty,
  output hvr_pkg::ring_job_t  head
);

  hvr_pkg::ring_job_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

/* design/hvr_back.sv */
`default_nettype none
`include "assert_macros.svh"
// walks the ring for one host, one slot per cycle unless the output is stalled, into the output register
module hvr_back #(
  parameter int unsigned VNODES = 3
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        job_valid,
  input  wire hvr_pkg::ring_job_t    job,
  output logic                       job_pop,
  input  wire  [hvr_pkg::BC_W-1:0]   ring_size,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [31:0]                out_vnode_index,
  output logic [3:0]                 out_slot,
  output logic                       out_unavailable,
  output logic                       out_no_blocks,
  output logic                       out_last
);

  localparam logic [hvr_pkg::SLOT_W-1:0] LAST_SLOT = hvr_pkg::SLOT_W'(VNODES - 1);

  logic                          active_r, nob_r, out_valid_r;
  logic [hvr_pkg::SLOT_W-1:0]    slot_r;
  logic [hvr_pkg::BC_W-1:0]      blk_r, step_r, blk_nxt;
  logic [hvr_pkg::BC_W-1:0]      placed_r [VNODES];
  logic [VNODES-1:0]             hit;
  logic [hvr_pkg::BC_W:0]        sum;
  logic                          emit, rep, is_last;
  logic [31:0]                   idx_r;
  logic [3:0]                    oslot_r;
  logic                          unav_r, onob_r, olast_r;

  assign emit    = active_r && (!out_valid_r || !out_stall);
  assign job_pop = !active_r && job_valid;
  assign is_last = nob_r || (slot_r == LAST_SLOT);
  assign rep     = |hit;

  // compare against earlier slots of this host
  always_comb begin
    for (int j = 0; j < VNODES; j++) begin
      hit[j] = (hvr_pkg::SLOT_W'(j) < slot_r) && (placed_r[j] == blk_r);
    end
  end

  // advance around the ring
  always_comb begin
    sum = {1'b0, blk_r} + {1'b0, step_r};
    if (sum >= {1'b0, ring_size}) blk_nxt = hvr_pkg::BC_W'(sum - {1'b0, ring_size});
    else                          blk_nxt = sum[hvr_pkg::BC_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_pop) active_r <= 1'b1;
      else if (emit && is_last) active_r <= 1'b0;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // walk state and result register
  always_ff @(posedge clk) begin
    if (job_pop) begin
      nob_r  <= job.no_blocks;
      blk_r  <= job.start;
      step_r <= job.step;
      slot_r <= '0;
    end else if (emit) begin
      blk_r  <= blk_nxt;
      slot_r <= slot_r + 1'b1;
    end
    if (emit) begin
      idx_r   <= (nob_r || rep) ? '0 : blk_r;
      oslot_r <= nob_r ? '0 : slot_r;
      unav_r  <= !nob_r && rep;
      onob_r  <= nob_r;
      olast_r <= is_last;
    end
  end

  // remember each slot's block
  for (genvar g = 0; g < VNODES; g++) begin : g_placed
    always_ff @(posedge clk) begin
      if (emit && (slot_r == hvr_pkg::SLOT_W'(g))) placed_r[g] <= blk_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_vnode_index = idx_r;
  assign out_slot        = oslot_r;
  assign out_unavailable = unav_r;
  assign out_no_blocks   = onob_r;
  assign out_last        = olast_r;

  `HVR_ASSERT_IMP(a_nob_last, clk, rst_n, out_valid && out_no_blocks, out_last)
  `HVR_ASSERT_IMP(a_unav_zero, clk, rst_n, out_valid && out_unavailable, out_vnode_index == '0)
  `HVR_ASSERT_IMP(a_slot_range, clk, rst_n, out_valid, out_slot <= LAST_SLOT)
  `HVR_ASSERT_NXT(a_last_idle, clk, rst_n, emit && is_last && !job_pop, !active_r)

endmodule
`default_nettype wire

/* design/host_vnode_ring_placement_core.sv */
`default_nettype none
// host placement on a ring of data blocks with VNODES virtual nodes per host
// input channel: in_valid / in_stall carry one host request (address and port)
// output channel: out_valid / out_stall carry one result per virtual node,
//   slot 0 first, out_last on the final one; an empty ring gives one result
//   flagged out_no_blocks
// configuration: apb port, ring size register at byte address 0; a write
//   holds in_stall high in its access cycle and while the spacing terms
//   are derived by reciprocal multiplication
// a request taken on a nonempty ring passes key reduction and then start
//   folding in the bit-serial divider lanes, then the queue and the output
//   register; an empty ring skips the divider lanes
// the front end takes a new host only once the lanes are done with the last
//   and its job is queued; the back end emits VNODES results at one per cycle from a queue while out_stall is low
// reset: ring size zero, queue empty, no result pending
// a stalled receiver holds the output register; the queue then fills and
//   in_stall stays high
module host_vnode_ring_placement_core #(
  parameter int unsigned VNODES = 3
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] in_ip_word,
  input  wire  [15:0] in_port_number,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_vnode_index,
  output logic [3:0]  out_slot,
  output logic        out_unavailable,
  output logic        out_no_blocks,
  output logic        out_last,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [hvr_pkg::BC_W-1:0] ring_size_r;
  logic                     cfg_wr;
  logic                     job_valid, job_full, q_valid, q_pop;
  hvr_pkg::ring_job_t       job, q_head;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == hvr_pkg::REG_RING_SIZE);
  assign prdata = (paddr[2] == hvr_pkg::REG_RING_SIZE) ? ring_size_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= '0;
    end else if (cfg_wr) begin
      ring_size_r <= pwdata;
    end
  end

  hvr_front #(.VNODES(VNODES)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_wr(cfg_wr),
    .ring_size(ring_size_r), .in_valid(in_valid), .in_stall(in_stall),
    .in_ip_word(in_ip_word), .in_port_number(in_port_number),
    .job_valid(job_valid), .job(job), .job_full(job_full)
  );

  hvr_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(job_valid), .push_job(job), .full(job_full),
    .pop(q_pop), .not_empty(q_valid), .head(q_head)
  );

  hvr_back #(.VNODES(VNODES)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job(q_head), .job_pop(q_pop),
    .ring_size(ring_size_r), .out_valid(out_valid), .out_stall(out_stall),
    .out_vnode_index(out_vnode_index), .out_slot(out_slot),
    .out_unavailable(out_unavailable), .out_no_blocks(out_no_blocks), .out_last(out_last)
  );

endmodule
`default_nettype wire
